FILE: design/boq_pkg.sv
// ----------------------------------------------------------------------------
// boq_pkg: shared types and codes
// Request and result payloads, request kinds and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package boq_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  chrom_id;
    logic [30:0] start_coord;
    logic [30:0] end_coord;
    logic [1:0]  strand_code;
    logic        strand_match;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] hit_index;
    logic [30:0] hit_start;
    logic [30:0] hit_end;
    logic [1:0]  hit_strand;
  } res_t;

  // front to back handshake
  typedef struct packed {
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic pop;
  } q_ctrl_t;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_NEXT  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_HIT      = 3'd4;
  localparam logic [2:0] ST_NO_MORE  = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam int unsigned BIN_SHIFT_RESET = 14;

endpackage
`default_nettype wire

FILE: design/boq_ram.sv
// ----------------------------------------------------------------------------
// boq_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module boq_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: design/boq_front.sv
// ----------------------------------------------------------------------------
// boq_front: request intake
// Two-entry request queue that decouples intake from execution.
// ----------------------------------------------------------------------------
`default_nettype none
module boq_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire boq_pkg::req_t  req_i,
  input  wire boq_pkg::q_ctrl_t ctrl_i,
  output boq_pkg::q_stat_t    stat_o,
  output boq_pkg::req_t       req_o
);
  import boq_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign pop         = ctrl_i.pop && (cnt_q != 2'd0);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: design/boq_back.sv
// ----------------------------------------------------------------------------
// boq_back: request execution
// Loads entries and fills bins, runs query and next scans over the table, clears it.
// ----------------------------------------------------------------------------
`default_nettype none
module boq_back #(
  parameter int unsigned MAX_ENTRIES    = 4096,
  parameter int unsigned MAX_CHROMS     = 8,
  parameter int unsigned BINS_PER_CHROM = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [4:0]        bin_shift_i,
  input  wire boq_pkg::q_stat_t  stat_i,
  input  wire boq_pkg::req_t     req_i,
  output boq_pkg::q_ctrl_t       ctrl_o,
  output logic                   done_o,
  output boq_pkg::res_t          res_o
);
  import boq_pkg::*;

  localparam int unsigned EW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW  = (MAX_CHROMS > 1) ? $clog2(MAX_CHROMS) : 1;
  localparam int unsigned CCW = $clog2(MAX_CHROMS + 1);
  localparam int unsigned BW  = (BINS_PER_CHROM > 1) ? $clog2(BINS_PER_CHROM) : 1;
  localparam int unsigned FW  = $clog2(BINS_PER_CHROM + 1);
  localparam int unsigned SD  = MAX_CHROMS * BINS_PER_CHROM;
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned ENW = 64;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LD_CHK = 10'b0000000010,
    S_LD_FIL = 10'b0000000100,
    S_Q_CHK  = 10'b0000001000,
    S_Q_BIN  = 10'b0000010000,
    S_Q_SCAN = 10'b0000100000,
    S_Q_TST  = 10'b0001000000,
    S_N_SCAN = 10'b0010000000,
    S_N_TST  = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  req_t   cur_q;

  logic [EW-1:0]  base_q   [MAX_CHROMS];
  logic [EW-1:0]  count_q  [MAX_CHROMS];
  logic [FW-1:0]  filled_q [MAX_CHROMS];
  logic           closed_q [MAX_CHROMS];
  logic [EW-1:0]  total_q;
  logic [CCW-1:0] cur_chrom_q;
  logic [30:0]    last_q, qs_q, qe_q;
  logic [1:0]     qstr_q;
  logic [EW-1:0]  cursor_q, limit_q, idx_q, lim_q;
  logic           missing_q;
  logic [FW-1:0]  pos_q, bin_q;

  // RAM ports
  logic           bin_we, bin_re, ent_we, ent_re;
  logic [SAW-1:0] bin_waddr, bin_raddr;
  logic [EAW-1:0] bin_rdata, ent_raddr;
  logic [ENW-1:0] ent_wdata, ent_rdata;
  logic [30:0]    e_start, e_end;
  logic [1:0]     e_strand;

  logic [CW-1:0]  cidx;
  logic           ch_bad, fresh, ld_reject, overlap, str_ok;
  logic [30:0]    ld_bin_full, q_bin_full;
  logic           done_d;
  res_t           res_d;

  assign cidx        = CW'(cur_q.chrom_id);
  assign ch_bad      = 32'(cur_q.chrom_id) >= MAX_CHROMS;
  assign fresh       = 32'(cur_q.chrom_id) != 32'(cur_chrom_q);
  assign ld_bin_full = (cur_q.end_coord - 31'd1) >> bin_shift_i;
  assign q_bin_full  = cur_q.start_coord >> bin_shift_i;
  assign ld_reject   = ch_bad || (cur_q.end_coord == 31'd0) ||
                       (32'(total_q) >= MAX_ENTRIES) ||
                       (fresh && (closed_q[cidx] || count_q[cidx] != '0)) ||
                       (!fresh && cur_q.start_coord < last_q) ||
                       (32'(ld_bin_full) >= BINS_PER_CHROM);

  assign {e_start, e_end, e_strand} = ent_rdata[63:0];
  assign overlap = (e_start < qe_q) && (qs_q < e_end);
  assign str_ok  = !cur_q.strand_match || (e_strand == qstr_q);

  assign bin_waddr = SAW'(SAW'(cidx) * SAW'(BINS_PER_CHROM) + SAW'(pos_q));
  assign bin_raddr = SAW'(SAW'(cidx) * SAW'(BINS_PER_CHROM) + SAW'(q_bin_full[BW-1:0]));
  assign ent_wdata = {cur_q.start_coord, cur_q.end_coord, cur_q.strand_code};
  assign ent_raddr = (state_q == S_N_SCAN) ? cursor_q[EAW-1:0] : idx_q[EAW-1:0];

  boq_ram #(.W(EAW), .D(SD)) u_bin_ram (
    .clk_i, .we_i(bin_we), .waddr_i(bin_waddr), .wdata_i(total_q[EAW-1:0]),
    .re_i(bin_re), .raddr_i(bin_raddr), .rdata_o(bin_rdata)
  );

  boq_ram #(.W(ENW), .D(MAX_ENTRIES)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(total_q[EAW-1:0]), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  always_comb begin
    state_d     = state_q;
    ctrl_o.pop  = 1'b0;
    done_d      = 1'b0;
    res_d       = '0;
    bin_we      = 1'b0;
    bin_re      = 1'b0;
    ent_we      = 1'b0;
    ent_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (stat_i.valid) begin
          ctrl_o.pop = 1'b1;
          case (req_i.req_type)
            REQ_LOAD:  state_d = S_LD_CHK;
            REQ_QUERY: state_d = S_Q_CHK;
            REQ_NEXT: begin
              if (missing_q) begin
                done_d       = 1'b1;
                res_d.status = ST_NO_MORE;
              end else begin
                state_d = S_N_SCAN;
              end
            end
            default: begin
              done_d       = 1'b1;
              res_d.status = ST_CLEARED;
            end
          endcase
        end
      end
      S_LD_CHK: begin
        if (ld_reject) begin
          done_d       = 1'b1;
          res_d.status = ST_REJECTED;
          state_d      = S_IDLE;
        end else begin
          state_d = S_LD_FIL;
        end
      end
      S_LD_FIL: begin
        if (pos_q <= bin_q) begin
          bin_we = 1'b1;
        end else begin
          ent_we          = 1'b1;
          done_d          = 1'b1;
          res_d.status    = ST_LOADED;
          res_d.hit_index = 12'(total_q);
          res_d.hit_start = cur_q.start_coord;
          res_d.hit_end   = cur_q.end_coord;
          res_d.hit_strand = cur_q.strand_code;
          state_d         = S_IDLE;
        end
      end
      S_Q_CHK: begin
        if (ch_bad || count_q[cidx] == '0 ||
            32'(q_bin_full) >= 32'(filled_q[cidx])) begin
          done_d       = 1'b1;
          res_d.status = ST_NONE;
          state_d      = S_IDLE;
        end else begin
          bin_re  = 1'b1;
          state_d = S_Q_BIN;
        end
      end
      S_Q_BIN: state_d = S_Q_SCAN;
      S_Q_SCAN: begin
        if (idx_q >= lim_q) begin
          done_d       = 1'b1;
          res_d.status = ST_NONE;
          state_d      = S_IDLE;
        end else begin
          ent_re  = 1'b1;
          state_d = S_Q_TST;
        end
      end
      S_Q_TST: begin
        if (overlap) begin
          done_d          = 1'b1;
          res_d.status    = ST_READY;
          res_d.hit_index = 12'(idx_q);
          state_d         = S_IDLE;
        end else begin
          state_d = S_Q_SCAN;
        end
      end
      S_N_SCAN: begin
        if (cursor_q >= limit_q) begin
          done_d       = 1'b1;
          res_d.status = ST_NO_MORE;
          state_d      = S_IDLE;
        end else begin
          ent_re  = 1'b1;
          state_d = S_N_TST;
        end
      end
      S_N_TST: begin
        if (e_start >= qe_q) begin
          done_d       = 1'b1;
          res_d.status = ST_NO_MORE;
          state_d      = S_IDLE;
        end else if (overlap && str_ok) begin
          done_d           = 1'b1;
          res_d.status     = ST_HIT;
          res_d.hit_index  = 12'(cursor_q);
          res_d.hit_start  = e_start;
          res_d.hit_end    = e_end;
          res_d.hit_strand = e_strand;
          state_d          = S_IDLE;
        end else begin
          state_d = S_N_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_o.pop) cur_q <= req_i;
    res_o <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_o      <= 1'b0;
      total_q     <= '0;
      cur_chrom_q <= CCW'(MAX_CHROMS);
      last_q      <= '0;
      qs_q        <= '0;
      qe_q        <= '0;
      qstr_q      <= '0;
      cursor_q    <= '0;
      limit_q     <= '0;
      idx_q       <= '0;
      lim_q       <= '0;
      missing_q   <= 1'b1;
      pos_q       <= '0;
      bin_q       <= '0;
      for (int i = 0; i < MAX_CHROMS; i++) begin
        base_q[i]   <= '0;
        count_q[i]  <= '0;
        filled_q[i] <= '0;
        closed_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
      case (state_q)
        S_IDLE: begin
          if (stat_i.valid && req_i.req_type == REQ_CLEAR) begin
            total_q     <= '0;
            cur_chrom_q <= CCW'(MAX_CHROMS);
            last_q      <= '0;
            qs_q        <= '0;
            qe_q        <= '0;
            qstr_q      <= '0;
            cursor_q    <= '0;
            limit_q     <= '0;
            missing_q   <= 1'b1;
            for (int i = 0; i < MAX_CHROMS; i++) begin
              base_q[i]   <= '0;
              count_q[i]  <= '0;
              filled_q[i] <= '0;
              closed_q[i] <= 1'b0;
            end
          end
        end
        S_LD_CHK: begin
          if (!ld_reject) begin
            bin_q <= FW'(ld_bin_full);
            if (fresh) begin
              if (32'(cur_chrom_q) < MAX_CHROMS) begin
                closed_q[CW'(cur_chrom_q)] <= 1'b1;
              end
              cur_chrom_q     <= CCW'(cur_q.chrom_id);
              base_q[cidx]    <= total_q;
              count_q[cidx]   <= '0;
              filled_q[cidx]  <= '0;
              pos_q           <= '0;
            end else begin
              pos_q <= filled_q[cidx];
            end
          end
        end
        S_LD_FIL: begin
          if (pos_q <= bin_q) begin
            pos_q <= pos_q + FW'(1);
          end else begin
            // pos_q ended at max(filled, bin+1)
            filled_q[cidx] <= pos_q;
            count_q[cidx]  <= count_q[cidx] + EW'(1);
            total_q        <= total_q + EW'(1);
            last_q         <= cur_q.start_coord;
          end
        end
        S_Q_CHK: begin
          missing_q <= 1'b1;
          qs_q      <= cur_q.start_coord;
          qe_q      <= cur_q.end_coord;
          qstr_q    <= cur_q.strand_code;
          lim_q     <= base_q[cidx] + count_q[cidx];
        end
        S_Q_BIN: idx_q <= EW'(bin_rdata);
        S_Q_TST: begin
          if (overlap) begin
            cursor_q  <= idx_q;
            limit_q   <= lim_q;
            missing_q <= 1'b0;
          end else begin
            idx_q <= idx_q + EW'(1);
          end
        end
        S_N_TST: begin
          if (e_start < qe_q) begin
            cursor_q <= cursor_q + EW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/binned_interval_overlap_query.sv
// Throughput: one request in execution at a time, set by the single entry RAM
// read port and the bin fill loop; a two-entry queue takes requests meanwhile.
// Reset: asynchronous, empties the table and ends any query, bin_shift = 14.
// Results come out as one-cycle done_o strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// binned_interval_overlap_query: top level
// Interval table with per-chromosome bin index and overlap scan.
// ----------------------------------------------------------------------------
`default_nettype none
module binned_interval_overlap_query #(
  parameter int unsigned MAX_ENTRIES    = 4096,
  parameter int unsigned MAX_CHROMS     = 8,
  parameter int unsigned BINS_PER_CHROM = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire boq_pkg::req_t req_i,
  output logic               done_o,
  output boq_pkg::res_t      res_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [4:0]    cfg_data_i
);
  import boq_pkg::*;

  q_stat_t    q_stat;
  q_ctrl_t    q_ctrl;
  req_t       q_req;
  logic [4:0] bin_shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_shift_q <= 5'(BIN_SHIFT_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      bin_shift_q <= cfg_data_i;
    end
  end

  boq_front u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .ctrl_i(q_ctrl), .stat_o(q_stat), .req_o(q_req)
  );

  boq_back #(
    .MAX_ENTRIES(MAX_ENTRIES), .MAX_CHROMS(MAX_CHROMS),
    .BINS_PER_CHROM(BINS_PER_CHROM)
  ) u_back (
    .clk_i, .rst_ni, .bin_shift_i(bin_shift_q), .stat_i(q_stat),
    .req_i(q_req), .ctrl_o(q_ctrl), .done_o, .res_o
  );
endmodule
`default_nettype wire

FILE: design/boq_checker.sv
// ----------------------------------------------------------------------------
// boq_checker: port-level checks
// Watches the top level's ports and flags result and config-port patterns that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none
module boq_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          done_o,
  input wire boq_pkg::res_t res_o,
  input wire logic          cfg_ready_o
);
  import boq_pkg::*;

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.status <= ST_CLEARED) else $error("bad status");

  a_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == ST_REJECTED || res_o.status == ST_NONE ||
               res_o.status == ST_NO_MORE || res_o.status == ST_CLEARED)
    |-> res_o.hit_index == '0 && res_o.hit_start == '0 && res_o.hit_end == '0)
    else $error("payload on empty result");

  a_ready_no_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == ST_READY |-> res_o.hit_start == '0)
    else $error("query ready carries coordinates");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o) else $error("config port not ready");
endmodule

bind binned_interval_overlap_query boq_checker u_boq_checker (
  .clk_i, .rst_ni, .done_o, .res_o, .cfg_ready_o
);
`default_nettype wire
